FILE: rtl/kmp_pkg.sv
// Shared definitions for the KMP stream matcher: request codes, default sizes,
// and the report record passed from the sequencer to the output stage.
// No dependencies.
package kmp_pkg;

    localparam int MAX_PATTERN_DEF   = 64;
    localparam int POSITION_BITS_DEF = 32;
    localparam int BYTE_BITS         = 8;
    localparam int INDEX_BITS        = 32;
    localparam int REQ_BITS          = 2;

    // request codes; the unused code is handled as an end request
    localparam logic [REQ_BITS-1:0] REQ_PATTERN = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_TEXT    = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_END     = 2'd2;

    typedef struct packed {
        logic                  valid;
        logic                  found;
        logic [INDEX_BITS-1:0] first_index;
        logic                  overflow;
    } t_report;

endpackage

FILE: rtl/kmp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module kmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/kmp_seq.sv
// Matcher sequencer: builds the failure table for pattern bytes and walks the
// text match through it, one byte compare per cycle. Uses kmp_pkg; drives the
// pattern store and failure table RAMs that live in the top level.
module kmp_seq #(
    parameter int MAX_PATTERN   = kmp_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_BITS = kmp_pkg::POSITION_BITS_DEF,
    parameter int AW            = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1,
    parameter int LW            = $clog2(MAX_PATTERN + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [kmp_pkg::REQ_BITS-1:0]   i_req_type,
    input  logic [kmp_pkg::BYTE_BITS-1:0]  i_byte_value,
    input  logic                           i_rep_ready,
    output kmp_pkg::t_report               o_rep,
    output logic                           o_st_we,
    output logic [AW-1:0]                  o_st_waddr,
    output logic [kmp_pkg::BYTE_BITS-1:0]  o_st_wdata,
    output logic [AW-1:0]                  o_st_raddr,
    input  logic [kmp_pkg::BYTE_BITS-1:0]  i_st_rdata,
    output logic                           o_ft_we,
    output logic [AW-1:0]                  o_ft_waddr,
    output logic [LW-1:0]                  o_ft_wdata,
    output logic [AW-1:0]                  o_ft_raddr,
    input  logic [LW-1:0]                  i_ft_rdata
);
    import kmp_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_PAT, S_CMP, S_REPORT} t_state;

    t_state                   r_state, n_state;
    logic [LW-1:0]            r_plen, n_plen;
    logic [LW-1:0]            r_bpl, n_bpl;
    logic [LW-1:0]            r_mlen, n_mlen;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic                     r_seen, n_seen;
    logic [POSITION_BITS-1:0] r_start, n_start;
    logic                     r_open, n_open;
    logic                     r_ovf, n_ovf;
    logic [LW-1:0]            r_k, n_k;
    logic [BYTE_BITS-1:0]     r_byte, n_byte;
    logic                     r_is_text, n_is_text;

    logic [LW-1:0]                       plen_eff;
    logic [LW-1:0]                       text_k;
    logic [LW-1:0]                       k_fin;
    logic [LW-1:0]                       k_m1;
    logic                                eq;
    logic [POSITION_BITS-1:0]            pos_inc;
    logic [POSITION_BITS:0]              pos_p1;
    logic [POSITION_BITS:0]              plen_x;
    logic [POSITION_BITS-1:0]            start_calc;
    logic [POSITION_BITS+INDEX_BITS-1:0] start_wide;

    assign plen_eff   = r_open ? r_plen : '0;
    assign text_k     = (r_mlen >= r_plen) ? '0 : r_mlen;
    assign eq         = (i_st_rdata == r_byte);
    assign k_fin      = eq ? r_k + LW'(1) : '0;
    assign pos_inc    = (r_pos == '1) ? r_pos : r_pos + POSITION_BITS'(1);
    assign pos_p1     = {1'b0, r_pos} + (POSITION_BITS + 1)'(1);
    assign plen_x     = (POSITION_BITS + 1)'(r_plen);
    assign start_calc = (pos_p1 >= plen_x) ? POSITION_BITS'(pos_p1 - plen_x) : '0;
    assign start_wide = {{INDEX_BITS{1'b0}}, r_start};

    // read both RAMs for the compare step of the next cycle
    assign k_m1       = n_k - LW'(1);
    assign o_st_raddr = n_k[AW-1:0];
    assign o_ft_raddr = k_m1[AW-1:0];
    assign o_st_wdata = r_byte;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_plen     = r_plen;
        n_bpl      = r_bpl;
        n_mlen     = r_mlen;
        n_pos      = r_pos;
        n_seen     = r_seen;
        n_start    = r_start;
        n_open     = r_open;
        n_ovf      = r_ovf;
        n_k        = r_k;
        n_byte     = r_byte;
        n_is_text  = r_is_text;
        o_st_we    = 1'b0;
        o_st_waddr = plen_eff[AW-1:0];
        o_ft_we    = 1'b0;
        o_ft_waddr = r_plen[AW-1:0];
        o_ft_wdata = k_fin;
        o_rep      = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_byte = i_byte_value;
                    case (i_req_type)
                        REQ_PATTERN: begin
                            n_state = S_PAT;
                        end
                        REQ_TEXT: begin
                            n_open = 1'b0;
                            if (!r_seen && r_plen != '0) begin
                                n_k       = text_k;
                                n_is_text = 1'b1;
                                n_state   = S_CMP;
                            end else begin
                                n_pos = pos_inc;
                            end
                        end
                        default: begin
                            n_state = S_REPORT;
                        end
                    endcase
                end
            end
            S_PAT: begin
                // first byte after text or a report starts a new pattern
                if (!r_open) begin
                    n_plen  = '0;
                    n_bpl   = '0;
                    n_ovf   = 1'b0;
                    n_mlen  = '0;
                    n_pos   = '0;
                    n_seen  = 1'b0;
                    n_start = '0;
                    n_open  = 1'b1;
                end
                if (plen_eff >= LW'(MAX_PATTERN)) begin
                    // drop the byte
                    n_ovf   = 1'b1;
                    n_state = S_IDLE;
                end else if (plen_eff == '0) begin
                    o_st_we    = 1'b1;
                    o_ft_we    = 1'b1;
                    o_ft_waddr = '0;
                    o_ft_wdata = '0;
                    n_bpl      = '0;
                    n_plen     = LW'(1);
                    n_state    = S_IDLE;
                end else begin
                    o_st_we   = 1'b1;
                    n_k       = r_bpl;
                    n_is_text = 1'b0;
                    n_state   = S_CMP;
                end
            end
            S_CMP: begin
                if (!eq && r_k != '0) begin
                    // fall back through the failure table
                    n_k = i_ft_rdata;
                end else begin
                    n_state = S_IDLE;
                    if (r_is_text) begin
                        n_mlen = k_fin;
                        if (k_fin == r_plen) begin
                            n_seen  = 1'b1;
                            n_start = start_calc;
                        end
                        n_pos = pos_inc;
                    end else begin
                        o_ft_we = 1'b1;
                        n_bpl   = k_fin;
                        n_plen  = r_plen + LW'(1);
                    end
                end
            end
            S_REPORT: begin
                if (i_rep_ready) begin
                    o_rep.valid       = 1'b1;
                    o_rep.found       = r_seen || (r_plen == '0);
                    o_rep.first_index = r_seen ? start_wide[INDEX_BITS-1:0] : '0;
                    o_rep.overflow    = r_ovf;
                    n_mlen            = '0;
                    n_pos             = '0;
                    n_seen            = 1'b0;
                    n_start           = '0;
                    n_open            = 1'b0;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_plen  <= '0;
            r_bpl   <= '0;
            r_mlen  <= '0;
            r_pos   <= '0;
            r_seen  <= 1'b0;
            r_start <= '0;
            r_open  <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_plen  <= n_plen;
            r_bpl   <= n_bpl;
            r_mlen  <= n_mlen;
            r_pos   <= n_pos;
            r_seen  <= n_seen;
            r_start <= n_start;
            r_open  <= n_open;
            r_ovf   <= n_ovf;
        end
        r_k       <= n_k;
        r_byte    <= n_byte;
        r_is_text <= n_is_text;
    end

`ifndef NO_ASSERTIONS
    a_plen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_plen <= LW'(MAX_PATTERN))
        else $error("pattern length beyond store capacity");

    a_prefix_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_plen != '0) |-> (r_bpl < r_plen))
        else $error("build prefix length not below pattern length");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_k < r_plen))
        else $error("compare index outside stored pattern");

    a_seen_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_seen) |-> (r_mlen == r_plen))
        else $error("match flagged without a full match length");
`endif

endmodule

FILE: rtl/kmp_stream_matcher_core.sv
// Channel  | valid        | ready        | payload
// ---------+--------------+--------------+------------------------------------------
// in       | i_in_valid   | o_in_ready   | i_req_type, i_byte_value
// out      | o_out_valid  | i_out_ready  | o_found, o_first_index, o_pattern_overflow
//
// Input is taken only when idle. A text byte runs the compare loop on the pattern
// store and failure table read ports, again per fallback (not at all once matched
// or with no pattern); a pattern byte runs it after the pattern state (not the
// first or a dropped byte). An end request waits on a full output register.
// Synchronous active-low reset; the RAMs need no clearing pass.
// Depends on kmp_pkg, kmp_ram, kmp_seq.
module kmp_stream_matcher_core #(
    parameter int MAX_PATTERN   = kmp_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_BITS = kmp_pkg::POSITION_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [kmp_pkg::REQ_BITS-1:0]    i_req_type,
    input  logic [kmp_pkg::BYTE_BITS-1:0]   i_byte_value,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_found,
    output logic [kmp_pkg::INDEX_BITS-1:0]  o_first_index,
    output logic                            o_pattern_overflow
);
    import kmp_pkg::*;

    localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LW = $clog2(MAX_PATTERN + 1);

    t_report              rep;
    logic                 rep_ready;
    logic                 st_we;
    logic [AW-1:0]        st_waddr;
    logic [BYTE_BITS-1:0] st_wdata;
    logic [AW-1:0]        st_raddr;
    logic [BYTE_BITS-1:0] st_rdata;
    logic                 ft_we;
    logic [AW-1:0]        ft_waddr;
    logic [LW-1:0]        ft_wdata;
    logic [AW-1:0]        ft_raddr;
    logic [LW-1:0]        ft_rdata;

    logic                  r_out_valid;
    logic                  r_out_found;
    logic [INDEX_BITS-1:0] r_out_index;
    logic                  r_out_ovf;

    kmp_seq #(
        .MAX_PATTERN   (MAX_PATTERN),
        .POSITION_BITS (POSITION_BITS),
        .AW            (AW),
        .LW            (LW)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_byte_value (i_byte_value),
        .i_rep_ready  (rep_ready),
        .o_rep        (rep),
        .o_st_we      (st_we),
        .o_st_waddr   (st_waddr),
        .o_st_wdata   (st_wdata),
        .o_st_raddr   (st_raddr),
        .i_st_rdata   (st_rdata),
        .o_ft_we      (ft_we),
        .o_ft_waddr   (ft_waddr),
        .o_ft_wdata   (ft_wdata),
        .o_ft_raddr   (ft_raddr),
        .i_ft_rdata   (ft_rdata)
    );

    kmp_ram #(
        .WIDTH (BYTE_BITS),
        .DEPTH (MAX_PATTERN),
        .AW    (AW)
    ) u_pattern_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    kmp_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_PATTERN),
        .AW    (AW)
    ) u_failure_table (
        .i_clk   (i_clk),
        .i_we    (ft_we),
        .i_waddr (ft_waddr),
        .i_wdata (ft_wdata),
        .i_raddr (ft_raddr),
        .o_rdata (ft_rdata)
    );

    // output register: load when empty or being drained this cycle
    assign rep_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rep.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (rep.valid) begin
            r_out_found <= rep.found;
            r_out_index <= rep.first_index;
            r_out_ovf   <= rep.overflow;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_found            = r_out_found;
    assign o_first_index      = r_out_index;
    assign o_pattern_overflow = r_out_ovf;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rep.valid |-> (!r_out_valid || i_out_ready))
        else $error("report loaded over an untaken transfer");

    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_first_index == '0))
        else $error("index set on a not-found report");

    a_busy_no_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !rep.valid)
        else $error("report issued while taking input");
`endif

endmodule

FILE: verif/tb_kmp_stream_matcher_core.sv
// Self-checking testbench for kmp_stream_matcher_core: drives pattern, text and
// end requests under random stalls and checks every report against a predictor.
// Depends on kmp_pkg and the kmp_stream_matcher_core RTL.
`timescale 1ns / 1ps

class kmp_match_tracker;
    localparam int MAX_PAT  = kmp_pkg::MAX_PATTERN_DEF;
    localparam int POS_BITS = kmp_pkg::POSITION_BITS_DEF;
    localparam longint unsigned POS_MAX = (longint'(1) << POS_BITS) - 1;

    bit [7:0]         pat_bytes [MAX_PAT];
    int unsigned      fail_len  [MAX_PAT];
    int unsigned      pat_len;
    int unsigned      build_k;
    int unsigned      match_len;
    longint unsigned  text_pos;
    longint unsigned  match_start;
    bit               match_seen;
    bit               pat_open;
    bit               ovf_seen;
    kmp_pkg::t_report pending_reports[$];
    int               errors;
    int               checked;

    function void clear_match();
        match_len   = 0;
        text_pos    = 0;
        match_seen  = 0;
        match_start = 0;
    endfunction

    function void add_pattern_byte(bit [7:0] b);
        int unsigned i;
        int unsigned k;
        if (!pat_open) begin
            pat_len  = 0;
            build_k  = 0;
            ovf_seen = 0;
            clear_match();
            pat_open = 1;
        end
        if (pat_len >= MAX_PAT) begin
            ovf_seen = 1;
            return;
        end
        i = pat_len;
        pat_bytes[i] = b;
        if (i == 0) begin
            fail_len[0] = 0;
            build_k     = 0;
        end else begin
            k = build_k;
            while (k > 0 && k < MAX_PAT && pat_bytes[k] != b)
                k = fail_len[k-1];
            if (k < MAX_PAT && pat_bytes[k] == b)
                k++;
            fail_len[i] = k;
            build_k     = k;
        end
        pat_len = i + 1;
    endfunction

    function void add_text_byte(bit [7:0] b);
        int unsigned k;
        pat_open = 0;
        if (!match_seen && pat_len > 0) begin
            k = match_len;
            if (k >= pat_len)
                k = 0;
            // fall back through the failure table on a mismatch
            while (k > 0 && pat_bytes[k] != b)
                k = fail_len[k-1];
            if (pat_bytes[k] == b)
                k++;
            match_len = k;
            if (k == pat_len) begin
                match_seen = 1;
                if (text_pos + 1 >= longint'(k))
                    match_start = text_pos + 1 - k;
                else
                    match_start = 0;
            end
        end
        if (text_pos < POS_MAX)
            text_pos++;
    endfunction

    // Note an accepted request and queue the report it causes, if any.
    function void note_request(logic [1:0] req, logic [7:0] b);
        kmp_pkg::t_report rep;
        case (req)
            kmp_pkg::REQ_PATTERN: add_pattern_byte(b);
            kmp_pkg::REQ_TEXT:    add_text_byte(b);
            default: begin
                rep.valid       = 1'b1;
                rep.found       = match_seen || pat_len == 0;
                rep.first_index = match_seen ? match_start[31:0] : 32'd0;
                rep.overflow    = ovf_seen;
                pending_reports.push_back(rep);
                clear_match();
                pat_open = 0;
            end
        endcase
    endfunction

    function void check_report(logic found, logic [31:0] first_index, logic overflow);
        kmp_pkg::t_report exp_rep;
        if (pending_reports.size() == 0) begin
            $error("unexpected report: found=%0b first_index=%0d overflow=%0b",
                   found, first_index, overflow);
            errors++;
            return;
        end
        exp_rep = pending_reports.pop_front();
        checked++;
        if (found !== exp_rep.found) begin
            $error("found: expected %0b, actual %0b", exp_rep.found, found);
            errors++;
        end
        if (first_index !== exp_rep.first_index) begin
            $error("first_index: expected %0d, actual %0d", exp_rep.first_index, first_index);
            errors++;
        end
        if (overflow !== exp_rep.overflow) begin
            $error("pattern_overflow: expected %0b, actual %0b", exp_rep.overflow, overflow);
            errors++;
        end
    endfunction
endclass

module tb_kmp_stream_matcher_core;
    import kmp_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS = 670;
    localparam logic [REQ_BITS-1:0] REQ_UNUSED = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic [REQ_BITS-1:0]   in_req = '0;
    logic [BYTE_BITS-1:0]  in_byte = '0;
    logic                  out_ready = 1'b0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  o_found;
    logic [INDEX_BITS-1:0] o_first_index;
    logic                  o_pattern_overflow;

    kmp_match_tracker board = new();

    int send_idle_pct = 12;
    int recv_idle_pct = 82;
    int sent_items;
    int patterns_sent;
    int overflow_patterns;
    int cycles;
    logic [7:0] alpha[4];
    int         alpha_n;
    logic [7:0] cur_pat[$];

    kmp_stream_matcher_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (o_in_ready),
        .i_req_type         (in_req),
        .i_byte_value       (in_byte),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (out_ready),
        .o_found            (o_found),
        .o_first_index      (o_first_index),
        .o_pattern_overflow (o_pattern_overflow)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reports outstanding",
                     cycles, board.pending_reports.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Output side: check each transfer, then stall at random.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready)
            board.check_report(o_found, o_first_index, o_pattern_overflow);
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_item(input logic [REQ_BITS-1:0] req, input logic [7:0] b);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        in_byte  <= b;
        // hold until the transfer
        do @(posedge i_clk); while (!o_in_ready);
        board.note_request(req, b);
        sent_items++;
    endtask

    function automatic logic [7:0] pick_byte();
        if (alpha_n == 0)
            return 8'($urandom_range(255));
        return alpha[$urandom_range(alpha_n - 1)];
    endfunction

    task automatic choose_alphabet();
        // a small alphabet forces long fallback chains; sometimes use any byte
        if ($urandom_range(99) < 20) begin
            alpha_n = 0;
        end else begin
            alpha_n = $urandom_range(4, 2);
            for (int i = 0; i < 4; i++)
                alpha[i] = 8'($urandom_range(255));
        end
    endtask

    task automatic send_text(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 5)
                send_item(REQ_TEXT, 8'($urandom_range(255)));
            else
                send_item(REQ_TEXT, pick_byte());
        end
    endtask

    task automatic run_episode(input bit force_overflow);
        int len;
        int r;
        logic [7:0] b;
        if ($urandom_range(99) < 8) begin
            // broken sequence: random selectors and bytes
            repeat ($urandom_range(6, 1))
                send_item(REQ_BITS'($urandom_range(3)), 8'($urandom_range(255)));
            return;
        end
        if (force_overflow || cur_pat.size() == 0 || $urandom_range(99) < 55) begin
            r = $urandom_range(99);
            if (force_overflow) len = $urandom_range(72, 65);
            else if (r < 78)    len = $urandom_range(6, 1);
            else if (r < 92)    len = $urandom_range(20, 7);
            else if (r < 97)    len = $urandom_range(64, 50);
            else                len = $urandom_range(72, 65);
            choose_alphabet();
            cur_pat.delete();
            for (int i = 0; i < len; i++) begin
                b = pick_byte();
                if (i < MAX_PATTERN_DEF)
                    cur_pat.push_back(b);
                send_item(REQ_PATTERN, b);
            end
            patterns_sent++;
            if (len > MAX_PATTERN_DEF)
                overflow_patterns++;
        end
        repeat ($urandom_range(3, 1)) begin
            repeat ($urandom_range(3, 0)) begin
                send_text($urandom_range(6, 0));
                if ($urandom_range(99) < 50) begin
                    // embed the pattern, sometimes with its last byte corrupted
                    for (int i = 0; i < cur_pat.size(); i++) begin
                        b = cur_pat[i];
                        if (i == cur_pat.size() - 1 && $urandom_range(99) < 25)
                            b = ~b;
                        send_item(REQ_TEXT, b);
                    end
                end
            end
            send_item(($urandom_range(9) == 0) ? REQ_UNUSED : REQ_END,
                      8'($urandom_range(255)));
        end
    endtask

    task automatic run_directed();
        // empty pattern reports found at index 0, through both end codes
        send_item(REQ_END, 8'h00);
        send_item(REQ_UNUSED, 8'hFF);
        // text with no pattern stored
        send_item(REQ_TEXT, 8'h00);
        send_item(REQ_END, 8'h5A);
        // extreme byte values
        send_item(REQ_PATTERN, 8'hFF);
        send_item(REQ_PATTERN, 8'h00);
        send_item(REQ_TEXT, 8'hFF);
        send_item(REQ_TEXT, 8'h00);
        send_item(REQ_END, 8'hFF);
        // self-overlapping pattern with a fallback; later bytes only advance
        send_item(REQ_PATTERN, 8'h61);
        send_item(REQ_PATTERN, 8'h62);
        send_item(REQ_PATTERN, 8'h61);
        send_item(REQ_TEXT, 8'h61);
        send_item(REQ_TEXT, 8'h62);
        send_item(REQ_TEXT, 8'h78);
        send_item(REQ_TEXT, 8'h61);
        send_item(REQ_TEXT, 8'h62);
        send_item(REQ_TEXT, 8'h61);
        send_item(REQ_TEXT, 8'h62);
        send_item(REQ_TEXT, 8'h61);
        send_item(REQ_END, 8'h00);
        // pattern kept for reuse; no match this time
        send_item(REQ_TEXT, 8'h62);
        send_item(REQ_END, 8'h00);
        cur_pat = '{8'h61, 8'h62, 8'h61};
        alpha_n = 3;
        alpha   = '{8'h61, 8'h62, 8'h78, 8'h00};
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_episode(1'b1);
        while (sent_items < PHASE_ITEMS)
            run_episode(1'b0);

        send_idle_pct = 82;
        recv_idle_pct = 12;
        run_episode(1'b1);
        while (sent_items < 2 * PHASE_ITEMS)
            run_episode(1'b0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (sent_items < 3 * PHASE_ITEMS)
            run_episode(1'b0);

        in_valid <= 1'b0;
        while (board.pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests over %0d patterns (%0d over capacity)",
                 sent_items, patterns_sent, overflow_patterns);
        $display("Checked %0d reports, %0d field errors", board.checked, board.errors);
        if (board.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

FILE: sim.f
rtl/kmp_pkg.sv
rtl/kmp_ram.sv
rtl/kmp_seq.sv
rtl/kmp_stream_matcher_core.sv
verif/tb_kmp_stream_matcher_core.sv
